FILE: rtl/bcdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// types and constants shared by the bc1/bc2/bc3 texel decoder and its checker
// no dependencies

package bcdec_pkg;

	// format_mode register codes
	typedef enum logic [3:0] {
		FMT_BC1      = 4'd0,
		FMT_BC2      = 4'd1,
		FMT_BC3      = 4'd2,
		FMT_BGRA8    = 4'd3,
		FMT_BGRX8    = 4'd4,
		FMT_RGBA8    = 4'd5,
		FMT_B5G6R5   = 4'd6,
		FMT_B5G5R5A1 = 4'd7,
		FMT_B4G4R4A4 = 4'd8,
		FMT_A8       = 4'd9,
		FMT_R8       = 4'd10
	} fmt_t;

	// where the alpha byte of an emitted pixel comes from
	typedef enum logic [1:0] {
		ASRC_PAL = 2'd0,
		ASRC_BC2 = 2'd1,
		ASRC_BC3 = 2'd2
	} asrc_t;

	typedef struct packed {
		logic [63:0] alpha_half;
		logic [63:0] color_half;
		logic [2:0]  cols_valid;
		logic [2:0]  rows_valid;
	} blk_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic [1:0] pos_x;
		logic [1:0] pos_y;
		logic       last_pixel;
	} pix_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} rgba_t;

	// reciprocal constants for division by 3, 5 and 7 over the value ranges used
	localparam int unsigned DIV3_MUL  = 683;
	localparam int unsigned DIV3_SH   = 11;
	localparam int unsigned DIV5_MUL  = 3277;
	localparam int unsigned DIV7_MUL  = 2341;
	localparam int unsigned DIV57_SH  = 14;

endpackage

`default_nettype wire

FILE: rtl/bc1_bc2_bc3_texel_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// bc1/bc2/bc3 block decoder and raw pixel converter producing bgra8 pixels
// depends on bcdec_pkg
//
// usage
//   blk channel (blk_valid, blk_stall, blk) carries one 4x4 compressed block or one raw
//   pixel per transaction; pix channel (pix_valid, pix_stall, pix) carries one bgra8
//   pixel per transaction, row-major, clipped to the valid columns and rows, with
//   last_pixel set on the final pixel of each input transaction
//   cfg_we/cfg_data write format_mode; write it only while the block is idle
// pipeline
//   the first pixel of an item passes the input register, the emit stage and the output
//   register; a compressed block occupies the emit stage while its cols*rows pixels
//   go out, one pixel a cycle while the output is not stalled; raw pixels go through
//   one per cycle when not stalled; the emit stage's pixel counter sets that rate; the
//   input register takes the next item while a block is still being emitted
//   unknown formats and zero-extent compressed blocks are dropped without a result
// reset
//   pipeline emptied, format_mode back to bc1
// stall
//   a stalled pixel holds in the output register and the stages behind it hold; the
//   input stalls once the input register is full and cannot move on

module bc1_bc2_bc3_texel_decoder_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [3:0]           cfg_data,
	input  wire                 blk_valid,
	output logic                blk_stall,
	input  wire bcdec_pkg::blk_t blk,
	output logic                pix_valid,
	input  wire                 pix_stall,
	output bcdec_pkg::pix_t     pix
);
	import bcdec_pkg::*;

	function automatic rgba_t expand565(input logic [15:0] v);
		rgba_t c;
		c.blue  = {v[4:0], v[4:2]};
		c.green = {v[10:5], v[10:9]};
		c.red   = {v[15:11], v[15:13]};
		c.alpha = 8'hff;
		return c;
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] v);
		logic [19:0] pr;
		pr = 20'(v) * 20'(DIV3_MUL);
		return pr[DIV3_SH +: 8];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] v);
		logic [22:0] pr;
		pr = 23'(v) * 23'(DIV5_MUL);
		return pr[DIV57_SH +: 8];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] v);
		logic [22:0] pr;
		pr = 23'(v) * 23'(DIV7_MUL);
		return pr[DIV57_SH +: 8];
	endfunction

	fmt_t fmt_q;

	// input register
	logic v_s1;
	blk_t blk_s1;

	// emit stage: decoded block plus pixel counter
	logic            v_s2;
	rgba_t [3:0]     pal_s2;
	logic [7:0][7:0] al_s2;
	logic [63:0]     ah_s2;
	logic [31:0]     sel_s2;
	asrc_t           asrc_s2;
	logic [1:0]      xmax_s2;
	logic [1:0]      ymax_s2;
	logic [1:0]      pos_x_q;
	logic [1:0]      pos_y_q;

	// output register
	logic pix_valid_s3;
	pix_t pix_s3;

	// decode of the input register
	rgba_t [3:0]     pal_d;
	logic [7:0][7:0] al_d;
	asrc_t           asrc_d;
	logic [31:0]     sel_d;
	logic [1:0]      xmax_d;
	logic [1:0]      ymax_d;
	logic            drop_s1;
	logic            compressed;
	logic [15:0]     c0;
	logic [15:0]     c1;
	rgba_t           e0;
	rgba_t           e1;
	rgba_t           raw;
	logic            three;
	logic [7:0]      a0;
	logic [7:0]      a1;
	logic [7:0]      b0;
	logic [15:0]     w;
	logic [10:0]     anum;

	// handshake
	logic out_adv;
	logic emit;
	logic s2_last;
	logic s2_free;
	logic s1_go;
	logic s1_free;
	logic load_s2;

	// pixel selection
	logic [3:0] pidx;
	logic [1:0] sel;
	logic [3:0] nib;
	logic [5:0] bc3_bit;
	logic [2:0] aidx;
	pix_t       pix_d;

	always_comb begin
		c0 = blk_s1.color_half[15:0];
		c1 = blk_s1.color_half[31:16];
		e0 = expand565(c0);
		e1 = expand565(c1);
		a0 = blk_s1.alpha_half[7:0];
		a1 = blk_s1.alpha_half[15:8];
		b0 = blk_s1.color_half[7:0];
		w  = blk_s1.color_half[15:0];
		compressed = (fmt_q == FMT_BC1) || (fmt_q == FMT_BC2) || (fmt_q == FMT_BC3);
		three = (fmt_q == FMT_BC1) && (c0 <= c1);

		pal_d[0] = e0;
		pal_d[1] = e1;
		if (three) begin
			pal_d[2].blue  = 8'(({1'b0, e0.blue} + {1'b0, e1.blue}) >> 1);
			pal_d[2].green = 8'(({1'b0, e0.green} + {1'b0, e1.green}) >> 1);
			pal_d[2].red   = 8'(({1'b0, e0.red} + {1'b0, e1.red}) >> 1);
			pal_d[3]       = '0;
		end else begin
			pal_d[2].blue  = div3({1'b0, e0.blue, 1'b0} + {2'b0, e1.blue});
			pal_d[2].green = div3({1'b0, e0.green, 1'b0} + {2'b0, e1.green});
			pal_d[2].red   = div3({1'b0, e0.red, 1'b0} + {2'b0, e1.red});
			pal_d[3].blue  = div3({2'b0, e0.blue} + {1'b0, e1.blue, 1'b0});
			pal_d[3].green = div3({2'b0, e0.green} + {1'b0, e1.green, 1'b0});
			pal_d[3].red   = div3({2'b0, e0.red} + {1'b0, e1.red, 1'b0});
			pal_d[3].alpha = 8'hff;
		end
		pal_d[2].alpha = 8'hff;

		// bc3 alpha table, eight steps when a0 > a1, else six plus 0 and 255
		al_d[0] = a0;
		al_d[1] = a1;
		for (int i = 2; i < 8; i++) begin
			if (a0 > a1) begin
				anum     = 11'((8 - i) * int'(a0) + (i - 1) * int'(a1));
				al_d[i]  = div7(anum);
			end else if (i < 6) begin
				anum     = 11'((6 - i) * int'(a0) + (i - 1) * int'(a1));
				al_d[i]  = div5(anum);
			end else begin
				anum     = '0;
				al_d[i]  = (i == 6) ? 8'h00 : 8'hff;
			end
		end

		raw.blue  = blk_s1.color_half[7:0];
		raw.green = blk_s1.color_half[15:8];
		raw.red   = blk_s1.color_half[23:16];
		raw.alpha = blk_s1.color_half[31:24];
		drop_s1   = 1'b0;
		case (fmt_q)
			FMT_BC1, FMT_BC2, FMT_BC3: begin
				drop_s1 = (blk_s1.cols_valid == 3'd0) || (blk_s1.rows_valid == 3'd0);
			end
			FMT_BGRA8: begin
			end
			FMT_BGRX8: begin
				raw.alpha = 8'hff;
			end
			FMT_RGBA8: begin
				raw.blue = blk_s1.color_half[23:16];
				raw.red  = blk_s1.color_half[7:0];
			end
			FMT_B5G6R5: begin
				raw = expand565(w);
			end
			FMT_B5G5R5A1: begin
				raw.blue  = {w[4:0], w[4:2]};
				raw.green = {w[9:5], w[9:7]};
				raw.red   = {w[14:10], w[14:12]};
				raw.alpha = w[15] ? 8'hff : 8'h00;
			end
			FMT_B4G4R4A4: begin
				// times 17 is the nibble repeated
				raw.blue  = {w[3:0], w[3:0]};
				raw.green = {w[7:4], w[7:4]};
				raw.red   = {w[11:8], w[11:8]};
				raw.alpha = {w[15:12], w[15:12]};
			end
			FMT_A8: begin
				raw.blue  = 8'hff;
				raw.green = 8'hff;
				raw.red   = 8'hff;
				raw.alpha = b0;
			end
			FMT_R8: begin
				raw.blue  = b0;
				raw.green = b0;
				raw.red   = b0;
				raw.alpha = 8'hff;
			end
			default: begin
				drop_s1 = 1'b1;
			end
		endcase

		case (fmt_q)
			FMT_BC2: asrc_d = ASRC_BC2;
			FMT_BC3: asrc_d = ASRC_BC3;
			default: asrc_d = ASRC_PAL;
		endcase

		if (compressed) begin
			sel_d  = blk_s1.color_half[63:32];
			xmax_d = (blk_s1.cols_valid >= 3'd4) ? 2'd3 : 2'(blk_s1.cols_valid - 3'd1);
			ymax_d = (blk_s1.rows_valid >= 3'd4) ? 2'd3 : 2'(blk_s1.rows_valid - 3'd1);
		end else begin
			// raw pixel rides as palette entry 0 of a one-pixel block
			pal_d[0] = raw;
			sel_d    = '0;
			xmax_d   = 2'd0;
			ymax_d   = 2'd0;
		end
	end

	assign out_adv   = !pix_valid_s3 || !pix_stall;
	assign emit      = v_s2 && out_adv;
	assign s2_last   = (pos_x_q == xmax_s2) && (pos_y_q == ymax_s2);
	assign s2_free   = !v_s2 || (out_adv && s2_last);
	assign s1_go     = v_s1 && (drop_s1 || s2_free);
	assign s1_free   = !v_s1 || s1_go;
	assign load_s2   = s1_go && !drop_s1;
	assign blk_stall = !s1_free;

	always_comb begin
		pidx    = {pos_y_q, pos_x_q};
		sel     = sel_s2[{pidx, 1'b0} +: 2];
		nib     = ah_s2[{pidx, 2'b00} +: 4];
		bc3_bit = 6'd16 + {1'b0, pidx, 1'b0} + {2'b00, pidx};
		aidx    = ah_s2[bc3_bit +: 3];
		pix_d.blue       = pal_s2[sel].blue;
		pix_d.green      = pal_s2[sel].green;
		pix_d.red        = pal_s2[sel].red;
		pix_d.pos_x      = pos_x_q;
		pix_d.pos_y      = pos_y_q;
		pix_d.last_pixel = s2_last;
		case (asrc_s2)
			ASRC_BC2: pix_d.alpha = {nib, nib};
			ASRC_BC3: pix_d.alpha = al_s2[aidx];
			default:  pix_d.alpha = pal_s2[sel].alpha;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_BC1;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			pos_x_q      <= 2'd0;
			pos_y_q      <= 2'd0;
			pix_valid_s3 <= 1'b0;
		end else begin
			if (cfg_we) begin
				fmt_q <= fmt_t'(cfg_data);
			end
			if (s1_free) begin
				v_s1 <= blk_valid;
			end
			if (s2_free) begin
				v_s2 <= load_s2;
			end
			if (load_s2 && s2_free) begin
				pos_x_q <= 2'd0;
				pos_y_q <= 2'd0;
			end else if (emit) begin
				if (pos_x_q == xmax_s2) begin
					pos_x_q <= 2'd0;
					pos_y_q <= pos_y_q + 2'd1;
				end else begin
					pos_x_q <= pos_x_q + 2'd1;
				end
			end
			if (out_adv) begin
				pix_valid_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_valid && s1_free) begin
			blk_s1 <= blk;
		end
		if (load_s2) begin
			pal_s2  <= pal_d;
			al_s2   <= al_d;
			ah_s2   <= blk_s1.alpha_half;
			sel_s2  <= sel_d;
			asrc_s2 <= asrc_d;
			xmax_s2 <= xmax_d;
			ymax_s2 <= ymax_d;
		end
		if (emit) begin
			pix_s3 <= pix_d;
		end
	end

	assign pix_valid = pix_valid_s3;
	assign pix       = pix_s3;

endmodule

`default_nettype wire

FILE: rtl/bcdec_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// port-level checker for the bc1/bc2/bc3 texel decoder, bound to the top level
// depends on bcdec_pkg

module bcdec_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  pix_valid,
	input wire                  pix_stall,
	input wire bcdec_pkg::pix_t pix
);
	import bcdec_pkg::*;

	// a stalled pixel stays offered unchanged
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("stalled pixel changed or dropped");

	// a block's pixels follow each other without bubbles
	a_block_burst: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !pix.last_pixel |=> pix_valid)
		else $error("gap inside a block");

	// within a block the position moves forward in row-major order
	a_raster_order: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && !pix.last_pixel |=>
		(pix.pos_y > $past(pix.pos_y)) ||
		((pix.pos_y == $past(pix.pos_y)) && (pix.pos_x > $past(pix.pos_x))))
		else $error("pixel position out of raster order");

	// an item that starts after an idle output begins at the top-left pixel
	a_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid) |-> (pix.pos_x == 2'd0) && (pix.pos_y == 2'd0))
		else $error("item does not start at the block origin");

endmodule

bind bc1_bc2_bc3_texel_decoder_top bcdec_chk u_bcdec_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.pix       (pix)
);

`default_nettype wire
